### sv/rrp_pkg.sv
// rrp_pkg: shared types and constants for the resp reply parser
// no dependencies; used by rrp_front, rrp_back and resp_reply_parser
`timescale 1ns / 1ps
`default_nettype none

package rrp_pkg;

    // deepest array nesting that can be open at once
    localparam int MAX_NEST = 16;
    localparam int LVL_W    = $clog2(MAX_NEST + 1);
    localparam int IDX_W    = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    // largest magnitude / 10, used by the overflow check
    localparam logic [62:0] DEC_LIMIT = 63'd922337203685477580;

    // parser states
    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_LINE_HEAD    = 4'd1,
        ST_NUM_HEAD     = 4'd2,
        ST_HEAD_LF      = 4'd3,
        ST_STR_BODY     = 4'd4,
        ST_STR_BODY_LF  = 4'd5,
        ST_ARR_BODY     = 4'd6,
        ST_LINE_BODY    = 4'd7,
        ST_SUB_STR_LEN  = 4'd8,
        ST_SUB_ARR_LEN  = 4'd9,
        ST_SUB_STR_LF   = 4'd10,
        ST_SUB_ARR_LF   = 4'd11,
        ST_SUB_STR_BODY = 4'd12,
        ST_ELEM_LF      = 4'd13,
        ST_FINISHED     = 4'd14,
        ST_ERROR        = 4'd15
    } state_t;

    // byte classes seen by the back end
    typedef enum logic [3:0] {
        CLS_PLUS,
        CLS_MINUS,
        CLS_COLON,
        CLS_DOLLAR,
        CLS_STAR,
        CLS_CR,
        CLS_LF,
        CLS_DIGIT,
        CLS_OTHER
    } cls_t;

    // status codes
    localparam logic [1:0] STAT_HEADER   = 2'd0;
    localparam logic [1:0] STAT_BODY     = 2'd1;
    localparam logic [1:0] STAT_COMPLETE = 2'd2;
    localparam logic [1:0] STAT_ERROR    = 2'd3;

    // reply kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_STATUS = 3'd1;
    localparam logic [2:0] KIND_ERROR  = 3'd2;
    localparam logic [2:0] KIND_INT    = 3'd3;
    localparam logic [2:0] KIND_BULK   = 3'd4;
    localparam logic [2:0] KIND_ARRAY  = 3'd5;

    // one classified beat in the queue
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       restart;
    } item_t;

endpackage

`default_nettype wire

### sv/rrp_front.sv
// rrp_front: accepts input beats, classifies the byte, two-entry queue
// depends on rrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          restart,
    output logic               q_valid,
    input  wire logic          q_pop,
    output rrp_pkg::item_t     q_item
);

    rrp_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    rrp_pkg::item_t cls_item;
    logic           push;
    logic           pop;

    // byte classification
    always_comb
    begin
        cls_item.restart = restart;
        cls_item.digit   = 4'(data_byte - 8'h30);
        case (data_byte)
            8'h2B:   cls_item.cls = rrp_pkg::CLS_PLUS;
            8'h2D:   cls_item.cls = rrp_pkg::CLS_MINUS;
            8'h3A:   cls_item.cls = rrp_pkg::CLS_COLON;
            8'h24:   cls_item.cls = rrp_pkg::CLS_DOLLAR;
            8'h2A:   cls_item.cls = rrp_pkg::CLS_STAR;
            8'h0D:   cls_item.cls = rrp_pkg::CLS_CR;
            8'h0A:   cls_item.cls = rrp_pkg::CLS_LF;
            default:
            begin
                if (data_byte inside {[8'h30:8'h39]})
                    cls_item.cls = rrp_pkg::CLS_DIGIT;
                else
                    cls_item.cls = rrp_pkg::CLS_OTHER;
            end
        endcase
    end

    // queue control
    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls_item;
    end

endmodule

`default_nettype wire

### sv/rrp_back.sv
// rrp_back: reply state machine, level stack and output register
// depends on rrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire rrp_pkg::item_t  q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           parse_status,
    output logic [2:0]           reply_kind,
    output logic signed [63:0]   header_value,
    output logic [4:0]           nest_depth
);

    localparam int LW = rrp_pkg::LVL_W;
    localparam int IW = rrp_pkg::IDX_W;

    rrp_pkg::state_t  state_reg, state_next, st_c;
    logic [2:0]       kind_reg, kind_next, kind_c;
    logic [63:0]      acc_reg, acc_next, acc_c;
    logic             neg_reg, neg_next, neg_c;
    logic [62:0]      blen_reg, blen_next, blen_c;
    logic [62:0]      bcnt_reg, bcnt_next, bcnt_c;
    logic [LW-1:0]    lc_reg, lc_next, lc_c;

    // per-level remaining element count and last-element flag
    logic [62:0]      rem_reg  [rrp_pkg::MAX_NEST];
    logic             last_reg [rrp_pkg::MAX_NEST];

    logic             out_valid_reg;
    logic [1:0]       stat_reg, stat_next;

    logic             take;
    logic             push_en;
    logic [62:0]      push_val;
    logic             fin_en;
    logic             found;
    logic [IW-1:0]    top_idx;
    logic [62:0]      top_rem;
    logic             stk_we;
    logic [IW-1:0]    stk_idx;
    logic [62:0]      stk_val;
    logic             stk_last;
    logic [63:0]      dig_acc;
    logic [63:0]      dig_len;
    rrp_pkg::cls_t    cls;

    // decimal step: {overflow, v * 10 + d}
    function automatic logic [63:0] add_dig(input logic [62:0] v, input logic [3:0] d);
        logic ovf;
        ovf = (v > rrp_pkg::DEC_LIMIT) || ((v == rrp_pkg::DEC_LIMIT) && (d > 4'd7));
        return {ovf, 63'((v << 3) + (v << 1) + 63'(d))};
    endfunction

    assign take  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = take;
    assign cls   = q_item.cls;

    // restart clears before the byte is parsed
    always_comb
    begin
        if (q_item.restart)
        begin
            st_c   = rrp_pkg::ST_IDLE;
            kind_c = rrp_pkg::KIND_NONE;
            acc_c  = '0;
            neg_c  = 1'b0;
            blen_c = '0;
            bcnt_c = '0;
            lc_c   = '0;
        end
        else
        begin
            st_c   = state_reg;
            kind_c = kind_reg;
            acc_c  = acc_reg;
            neg_c  = neg_reg;
            blen_c = blen_reg;
            bcnt_c = bcnt_reg;
            lc_c   = lc_reg;
        end
    end

    assign dig_acc = add_dig(acc_c[62:0], q_item.digit);
    assign dig_len = add_dig(blen_c, q_item.digit);

    // highest open level that is not on its last element
    always_comb
    begin
        found   = 1'b0;
        top_idx = '0;
        for (int i = 0; i < rrp_pkg::MAX_NEST; i++)
        begin
            if ((LW'(i) < lc_c) && !last_reg[i])
            begin
                found   = 1'b1;
                top_idx = IW'(i);
            end
        end
    end

    assign top_rem = rem_reg[top_idx];

    // next state
    always_comb
    begin
        state_next = st_c;
        kind_next  = kind_c;
        acc_next   = acc_c;
        neg_next   = neg_c;
        blen_next  = blen_c;
        bcnt_next  = bcnt_c;
        lc_next    = lc_c;
        push_en    = 1'b0;
        push_val   = blen_c;
        fin_en     = 1'b0;
        stk_we     = 1'b0;
        stk_idx    = lc_c[IW-1:0];
        stk_val    = push_val;
        stk_last   = 1'b0;

        case (st_c)
            rrp_pkg::ST_IDLE:
            begin
                state_next = rrp_pkg::ST_LINE_HEAD;
                case (cls)
                    rrp_pkg::CLS_PLUS:  kind_next = rrp_pkg::KIND_STATUS;
                    rrp_pkg::CLS_MINUS: kind_next = rrp_pkg::KIND_ERROR;
                    rrp_pkg::CLS_COLON:
                    begin
                        kind_next  = rrp_pkg::KIND_INT;
                        state_next = rrp_pkg::ST_NUM_HEAD;
                    end
                    rrp_pkg::CLS_DOLLAR:
                    begin
                        kind_next  = rrp_pkg::KIND_BULK;
                        state_next = rrp_pkg::ST_NUM_HEAD;
                    end
                    rrp_pkg::CLS_STAR:
                    begin
                        kind_next  = rrp_pkg::KIND_ARRAY;
                        state_next = rrp_pkg::ST_NUM_HEAD;
                    end
                    default: state_next = rrp_pkg::ST_ERROR;
                endcase
            end
            rrp_pkg::ST_LINE_HEAD:
            begin
                if (cls == rrp_pkg::CLS_CR)
                    state_next = rrp_pkg::ST_HEAD_LF;
            end
            rrp_pkg::ST_NUM_HEAD:
            begin
                if (cls == rrp_pkg::CLS_DIGIT)
                begin
                    if (dig_acc[63])
                        state_next = rrp_pkg::ST_ERROR;
                    else
                        acc_next = {1'b0, dig_acc[62:0]};
                end
                else if (cls == rrp_pkg::CLS_CR)
                begin
                    if (neg_c)
                        acc_next = 64'd0 - acc_c;
                    state_next = rrp_pkg::ST_HEAD_LF;
                end
                else if (cls == rrp_pkg::CLS_MINUS && !neg_c)
                    neg_next = 1'b1;
                else
                    state_next = rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_HEAD_LF:
            begin
                if (cls != rrp_pkg::CLS_LF)
                    state_next = rrp_pkg::ST_ERROR;
                else if (kind_c == rrp_pkg::KIND_STATUS || kind_c == rrp_pkg::KIND_ERROR
                         || kind_c == rrp_pkg::KIND_INT)
                    state_next = rrp_pkg::ST_FINISHED;
                else if (kind_c == rrp_pkg::KIND_BULK)
                begin
                    if (acc_c[63])
                        state_next = rrp_pkg::ST_FINISHED;
                    else
                    begin
                        blen_next  = acc_c[62:0];
                        bcnt_next  = '0;
                        state_next = rrp_pkg::ST_STR_BODY;
                    end
                end
                else if (kind_c == rrp_pkg::KIND_ARRAY)
                begin
                    if (acc_c[63] || acc_c == 64'd0)
                        state_next = rrp_pkg::ST_FINISHED;
                    else
                    begin
                        push_en  = 1'b1;
                        push_val = acc_c[62:0];
                    end
                end
                else
                    state_next = rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_STR_BODY:
            begin
                if (bcnt_c == blen_c)
                    state_next = (cls == rrp_pkg::CLS_CR) ? rrp_pkg::ST_STR_BODY_LF
                                                          : rrp_pkg::ST_ERROR;
                else
                    bcnt_next = bcnt_c + 63'd1;
            end
            rrp_pkg::ST_STR_BODY_LF:
            begin
                state_next = (cls == rrp_pkg::CLS_LF) ? rrp_pkg::ST_FINISHED
                                                      : rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_ARR_BODY:
            begin
                if (cls == rrp_pkg::CLS_PLUS || cls == rrp_pkg::CLS_MINUS
                    || cls == rrp_pkg::CLS_COLON)
                    state_next = rrp_pkg::ST_LINE_BODY;
                else if (cls == rrp_pkg::CLS_DOLLAR || cls == rrp_pkg::CLS_STAR)
                begin
                    neg_next   = 1'b0;
                    blen_next  = '0;
                    state_next = (cls == rrp_pkg::CLS_DOLLAR) ? rrp_pkg::ST_SUB_STR_LEN
                                                              : rrp_pkg::ST_SUB_ARR_LEN;
                end
                else
                    state_next = rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_LINE_BODY:
            begin
                if (cls == rrp_pkg::CLS_CR)
                    state_next = rrp_pkg::ST_ELEM_LF;
            end
            rrp_pkg::ST_SUB_STR_LEN, rrp_pkg::ST_SUB_ARR_LEN:
            begin
                if (cls == rrp_pkg::CLS_DIGIT)
                begin
                    if (dig_len[63])
                        state_next = rrp_pkg::ST_ERROR;
                    else
                        blen_next = dig_len[62:0];
                end
                else if (cls == rrp_pkg::CLS_CR)
                begin
                    if (neg_c)
                        state_next = rrp_pkg::ST_ELEM_LF;
                    else if (st_c == rrp_pkg::ST_SUB_STR_LEN)
                        state_next = rrp_pkg::ST_SUB_STR_LF;
                    else
                        state_next = (blen_c != '0) ? rrp_pkg::ST_SUB_ARR_LF
                                                    : rrp_pkg::ST_ELEM_LF;
                end
                else if (cls == rrp_pkg::CLS_MINUS && !neg_c)
                    neg_next = 1'b1;
                else
                    state_next = rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_SUB_STR_LF:
            begin
                bcnt_next  = '0;
                state_next = (cls == rrp_pkg::CLS_LF) ? rrp_pkg::ST_SUB_STR_BODY
                                                      : rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_SUB_ARR_LF:
            begin
                if (cls == rrp_pkg::CLS_LF)
                    push_en = 1'b1;
                else
                    state_next = rrp_pkg::ST_ERROR;
            end
            rrp_pkg::ST_SUB_STR_BODY:
            begin
                if (bcnt_c == blen_c)
                    state_next = (cls == rrp_pkg::CLS_CR) ? rrp_pkg::ST_ELEM_LF
                                                          : rrp_pkg::ST_ERROR;
                else
                    bcnt_next = bcnt_c + 63'd1;
            end
            rrp_pkg::ST_ELEM_LF:
            begin
                if (cls != rrp_pkg::CLS_LF)
                    state_next = rrp_pkg::ST_ERROR;
                else
                    fin_en = 1'b1;
            end
            default:
            begin
                state_next = st_c;
            end
        endcase

        // open a new array level
        if (push_en)
        begin
            if (lc_c >= LW'(rrp_pkg::MAX_NEST))
                state_next = rrp_pkg::ST_ERROR;
            else
            begin
                stk_we     = 1'b1;
                stk_idx    = lc_c[IW-1:0];
                stk_val    = push_val;
                stk_last   = (push_val == 63'd1);
                lc_next    = lc_c + LW'(1);
                state_next = rrp_pkg::ST_ARR_BODY;
            end
        end

        // one element done: pop all levels on their last element
        if (fin_en)
        begin
            if (found)
            begin
                stk_we     = 1'b1;
                stk_idx    = top_idx;
                stk_val    = top_rem - 63'd1;
                stk_last   = (top_rem == 63'd2);
                lc_next    = LW'(top_idx) + LW'(1);
                state_next = rrp_pkg::ST_ARR_BODY;
            end
            else
            begin
                lc_next    = '0;
                state_next = rrp_pkg::ST_FINISHED;
            end
        end

        // status code of the new state
        if (state_next == rrp_pkg::ST_ERROR)
            stat_next = rrp_pkg::STAT_ERROR;
        else if (state_next == rrp_pkg::ST_FINISHED)
            stat_next = rrp_pkg::STAT_COMPLETE;
        else if (state_next <= rrp_pkg::ST_HEAD_LF)
            stat_next = rrp_pkg::STAT_HEADER;
        else
            stat_next = rrp_pkg::STAT_BODY;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrp_pkg::ST_IDLE;
            kind_reg  <= rrp_pkg::KIND_NONE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            blen_reg  <= '0;
            bcnt_reg  <= '0;
            lc_reg    <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            blen_reg  <= blen_next;
            bcnt_reg  <= bcnt_next;
            lc_reg    <= lc_next;
        end
    end

    // level stack, written before it is read
    always_ff @(posedge clk)
    begin
        if (take && stk_we)
        begin
            rem_reg[stk_idx]  <= stk_val;
            last_reg[stk_idx] <= stk_last;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stat_reg <= stat_next;
    end

    assign out_valid    = out_valid_reg;
    assign parse_status = stat_reg;
    assign reply_kind   = kind_reg;
    assign header_value = acc_reg;
    assign nest_depth   = 5'(lc_reg);

endmodule

`default_nettype wire

### sv/resp_reply_parser.sv
// resp_reply_parser: top level, one reply byte in, one status beat out
// depends on rrp_pkg, rrp_front, rrp_back
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready data_byte restart            | sink
//  out     | out_valid out_ready parse_status reply_kind     | source
//          | header_value nest_depth                         |
//
// one byte per cycle sustained while out_ready stays high; the back end's state update is registered
// the front queue holds two classified bytes so the input can run ahead
// a held result in the output register stalls the back end; the front accepts until its queue is full
// reset clears all control state at once; the level stack needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module resp_reply_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              parse_status,
    output logic [2:0]              reply_kind,
    output logic signed [63:0]      header_value,
    output logic [4:0]              nest_depth
);

    logic           q_valid;
    logic           q_pop;
    rrp_pkg::item_t q_item;

    // accept and classify
    rrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .restart   (restart),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // parse and report
    rrp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parse_status (parse_status),
        .reply_kind   (reply_kind),
        .header_value (header_value),
        .nest_depth   (nest_depth)
    );

endmodule

`default_nettype wire
